/* hdl/ttpo_pkg.sv */
// shared types and constants for the timer table block
// no dependencies; imported by every module of the block
package ttpo_pkg;

   // table geometry
   localparam int TIMER_COUNT = 16;
   localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   // field widths
   localparam int KIND_W = 3;
   localparam int SEL_W  = 4;
   localparam int TIME_W = 32;

   // command queue between front and execution unit
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // request kind codes
   localparam logic [KIND_W-1:0] KIND_ARM_PERIODIC = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ARM_ONESHOT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DISARM       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SCAN         = 3'd3;
   localparam logic [KIND_W-1:0] KIND_QUERY        = 3'd4;

   // response kind codes
   localparam logic RESULT_EXPIRY = 1'b0;
   localparam logic RESULT_QUERY  = 1'b1;

   // decoded operation
   typedef enum logic [1:0] {
      OP_ARM    = 2'd0,
      OP_DISARM = 2'd1,
      OP_SCAN   = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   // queued command word
   typedef struct packed {
      op_type            op;
      logic              one_shot;
      logic [SEL_W-1:0]  sel;
      logic              in_range;
      logic [TIME_W-1:0] value;     // deadline for arm, current time for scan
      logic [TIME_W-1:0] interval;
   } cmd_type;

   // queue status seen by the producer and the consumer
   typedef struct packed {
      logic avail;
      logic full;
   } q_status_type;

endpackage

/* hdl/ttpo_front.sv */
// front end: accepts request words, decodes kind, checks the entry index
// and computes the arm deadline; depends on ttpo_pkg
module ttpo_front
   import ttpo_pkg::*;
(
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SEL_W-1:0]  req_timer_select,
   input  logic [TIME_W-1:0] req_interval,
   input  logic [TIME_W-1:0] req_now,
   input  q_status_type      q_status,
   output logic              q_push,
   output cmd_type           q_wdata
);

   logic in_range;
   logic keep;

   // entry index check against the table size
   assign in_range = (IDX_W + SEL_W)'(req_timer_select) < (IDX_W + SEL_W)'(TIMER_COUNT);

   // decode; out-of-range arm/disarm and unknown kinds are dropped here
   always_comb begin
      keep             = 1'b0;
      q_wdata.op       = OP_SCAN;
      q_wdata.one_shot = (req_kind == KIND_ARM_ONESHOT);
      q_wdata.sel      = req_timer_select;
      q_wdata.in_range = in_range;
      q_wdata.value    = req_now;
      q_wdata.interval = req_interval;
      case (req_kind)
         KIND_ARM_PERIODIC, KIND_ARM_ONESHOT: begin
            keep          = in_range;
            q_wdata.op    = OP_ARM;
            q_wdata.value = req_interval + req_now;
         end
         KIND_DISARM: begin
            keep       = in_range;
            q_wdata.op = OP_DISARM;
         end
         KIND_SCAN: begin
            keep       = 1'b1;
            q_wdata.op = OP_SCAN;
         end
         KIND_QUERY: begin
            keep       = 1'b1;
            q_wdata.op = OP_QUERY;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // handshake
   assign req_stall = q_status.full;
   assign q_push    = req_valid && !q_status.full && keep;

endmodule

/* hdl/ttpo_queue.sv */
// short command queue between the front end and the execution unit
// depends on ttpo_pkg
module ttpo_queue
   import ttpo_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      wdata,
   input  logic         pop,
   output cmd_type      rdata,
   output q_status_type status
);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.avail = (count_ff != '0);
   assign rdata        = slot_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.avail;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* hdl/ttpo_exec.sv */
// execution unit: holds the timer table, runs arm/disarm/query and the
// entry-by-entry scan, and drives the response register; depends on ttpo_pkg
module ttpo_exec
   import ttpo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  q_status_type      q_status,
   input  cmd_type           q_rdata,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_result_kind,
   output logic [SEL_W-1:0]  rsp_timer_index,
   output logic              rsp_enabled_flag,
   output logic              rsp_last
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic [TIME_W-1:0]   scan_now_ff, scan_now_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]    pend_idx_ff, pend_idx_in;

   // timer table
   logic [TIMER_COUNT-1:0] armed_ff;
   logic [TIME_W-1:0]      deadline_ff [TIMER_COUNT];
   logic [TIME_W-1:0]      period_ff   [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] single_ff;

   // response register
   logic                out_valid_ff, out_valid_in;
   logic                out_kind_ff, out_kind_in;
   logic [SEL_W-1:0]    out_idx_ff, out_idx_in;
   logic                out_en_ff, out_en_in;
   logic                out_last_ff, out_last_in;
   logic                out_load;
   logic                out_free;

   // table write controls
   logic                arm_we;
   logic                disarm_we;
   logic                upd_we;
   logic [IDX_W-1:0]    sel_idx;

   // scan datapath
   logic [TIME_W-1:0]   cur_deadline;
   logic [TIME_W-1:0]   sum_deadline;
   logic [TIME_W-1:0]   next_deadline;
   logic                hit;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign sel_idx  = IDX_W'(q_rdata.sel);

   // expiry test and periodic advance for the entry under the scan counter
   assign cur_deadline  = deadline_ff[cnt_ff];
   assign hit           = armed_ff[cnt_ff] && (cur_deadline <= scan_now_ff);
   assign sum_deadline  = cur_deadline + period_ff[cnt_ff];
   assign next_deadline = (sum_deadline < scan_now_ff) ? scan_now_ff : sum_deadline;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      scan_now_in   = scan_now_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      q_pop         = 1'b0;
      arm_we        = 1'b0;
      disarm_we     = 1'b0;
      upd_we        = 1'b0;
      out_load      = 1'b0;
      out_kind_in   = RESULT_EXPIRY;
      out_idx_in    = SEL_W'(pend_idx_ff);
      out_en_in     = 1'b0;
      out_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.avail) begin
               case (q_rdata.op)
                  OP_ARM: begin
                     q_pop  = 1'b1;
                     arm_we = 1'b1;
                  end
                  OP_DISARM: begin
                     q_pop     = 1'b1;
                     disarm_we = 1'b1;
                  end
                  OP_QUERY: begin
                     if (out_free) begin
                        q_pop       = 1'b1;
                        out_load    = 1'b1;
                        out_kind_in = RESULT_QUERY;
                        out_idx_in  = q_rdata.sel;
                        out_en_in   = q_rdata.in_range && armed_ff[sel_idx];
                        out_last_in = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     q_pop         = 1'b1;
                     scan_now_in   = q_rdata.value;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // a hit is held back until the next one is found so the final one can carry last
            if (!(hit && pend_valid_ff && !out_free)) begin
               if (hit) begin
                  upd_we        = 1'b1;
                  out_load      = pend_valid_ff;
                  pend_valid_in = 1'b1;
                  pend_idx_in   = cnt_ff;
               end
               if (cnt_ff == IDX_W'(TIMER_COUNT - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register next value
   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_now_ff <= scan_now_in;
      pend_idx_ff <= pend_idx_in;
      if (out_load) begin
         out_kind_ff <= out_kind_in;
         out_idx_ff  <= out_idx_in;
         out_en_ff   <= out_en_in;
         out_last_ff <= out_last_in;
      end
   end

   // enable bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else if (arm_we) begin
         armed_ff[sel_idx] <= 1'b1;
      end else if (disarm_we) begin
         armed_ff[sel_idx] <= 1'b0;
      end else if (upd_we && single_ff[cnt_ff]) begin
         armed_ff[cnt_ff] <= 1'b0;
      end
   end

   // deadline, period and one-shot mark
   always_ff @(posedge clock) begin
      if (arm_we) begin
         deadline_ff[sel_idx] <= q_rdata.value;
         period_ff[sel_idx]   <= q_rdata.interval;
         single_ff[sel_idx]   <= q_rdata.one_shot;
      end else if (upd_we && !single_ff[cnt_ff]) begin
         deadline_ff[cnt_ff] <= next_deadline;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_timer_index  = out_idx_ff;
   assign rsp_enabled_flag = out_en_ff;
   assign rsp_last         = out_last_ff;

endmodule

/* hdl/timer_table_periodic_oneshot.sv */
// Timer table with periodic and one-shot entries (16 entries). Request words
// are taken one per cycle into a 4-word command queue while it has room;
// out-of-range arm/disarm and unknown kinds are absorbed at the front. The
// execution unit takes arm, disarm and query straight from idle. A scan
// starts from idle, walks the table one entry per cycle, except while a found
// expiry waits on a stalled response, and then flushes the final word; it
// holds each expiry back until the next one is found so that the final
// response can carry last. Responses come from a single output register; a
// stalled response port holds up queries and scans, and requests stall only
// once the queue fills.
// depends on ttpo_pkg, ttpo_front, ttpo_queue, ttpo_exec
module timer_table_periodic_oneshot
   import ttpo_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [KIND_W-1:0] req_kind,
   input  logic [SEL_W-1:0]  req_timer_select,
   input  logic [TIME_W-1:0] req_interval,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_result_kind,
   output logic [SEL_W-1:0]  rsp_timer_index,
   output logic              rsp_enabled_flag,
   output logic              rsp_last
);

   q_status_type q_status;
   logic         q_push;
   logic         q_pop;
   cmd_type      q_wdata;
   cmd_type      q_rdata;

   // decode and deadline computation
   ttpo_front u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_timer_select (req_timer_select),
      .req_interval     (req_interval),
      .req_now          (req_now),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_wdata          (q_wdata)
   );

   // command queue
   ttpo_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // table and scan sequencer
   ttpo_exec u_exec (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_rdata          (q_rdata),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_timer_index  (rsp_timer_index),
      .rsp_enabled_flag (rsp_enabled_flag),
      .rsp_last         (rsp_last)
   );

endmodule

/* hdl/ttpo_checker.sv */
// port-level checks for the timer table block, bound to the top level
// depends on ttpo_pkg
module ttpo_checker
   import ttpo_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [KIND_W-1:0] req_kind,
   input logic [SEL_W-1:0]  req_timer_select,
   input logic [TIME_W-1:0] req_interval,
   input logic [TIME_W-1:0] req_now,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_result_kind,
   input logic [SEL_W-1:0]  rsp_timer_index,
   input logic              rsp_enabled_flag,
   input logic              rsp_last
);

   // a stalled request word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_kind)
         && $stable(req_timer_select) && $stable(req_interval) && $stable(req_now))
      else $error("request word changed while stalled");

   // a stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_timer_index) && $stable(rsp_enabled_flag) && $stable(rsp_last))
      else $error("response word changed while stalled");

   // expiry events never report an enable bit
   a_expiry_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_EXPIRY) |-> !rsp_enabled_flag)
      else $error("expiry event with enabled flag set");

   // a query answer is always the only word of its request
   a_query_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == RESULT_QUERY) |-> rsp_last)
      else $error("query answer without last");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind timer_table_periodic_oneshot ttpo_checker u_ttpo_checker (.*);
